// ===== src/b2da_pkg.sv =====
`default_nettype none
package b2da_pkg;

   localparam int unsigned BinWidth  = 16;
   localparam int unsigned NumDigits = 5;
   localparam int unsigned BcdWidth  = 4 * NumDigits;
   localparam int unsigned CntWidth  = 4;
   localparam int unsigned IdxWidth  = 3;
   localparam int unsigned CharWidth = 6;

   localparam logic [CntWidth-1:0]  LastShift  = CntWidth'(BinWidth - 1);
   localparam logic [CharWidth-1:0] DigitBase  = 6'd48;
   localparam logic [3:0]           AdjustMin  = 4'd5;
   localparam logic [3:0]           AdjustAdd  = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_FIND,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic find;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic conv_last;
      logic idx_zero;
   } status_type;

endpackage
`default_nettype wire

// ===== src/b2da_req_if.sv =====
`default_nettype none
interface b2da_req_if;
   logic                            valid;
   logic                            ready;
   logic [b2da_pkg::BinWidth-1:0]   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// ===== src/b2da_rsp_if.sv =====
`default_nettype none
interface b2da_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [b2da_pkg::CharWidth-1:0]  digit_char;
   logic                            last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface
`default_nettype wire

// ===== src/binary_to_decimal_ascii_top.sv =====
// an accepted input runs 16 shift-and-add-3 iterations, then a step to
// locate the leading digit, before the first digit beat; digits then go out
// one beat per cycle while rsp ready is high, one to five beats
// one number in flight; a new input is taken only after the last digit beat
// reset: synchronous active high, returns the controller to idle
`default_nettype none
module binary_to_decimal_ascii_top (
   input  wire logic   clock,
   input  wire logic   reset,
   b2da_req_if.sink    req_bus,
   b2da_rsp_if.source  rsp_bus
);

   b2da_pkg::cmd_type    cmd;
   b2da_pkg::status_type status;

   b2da_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   b2da_dp u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .value      (req_bus.value),
      .status     (status),
      .digit_char (rsp_bus.digit_char),
      .last_digit (rsp_bus.last_digit)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("input accepted while busy");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("input ready while digits pending");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.digit_char >= 6'd48 && rsp_bus.digit_char <= 6'd57))
      else $error("digit code out of range");

   a_end_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.last_digit) |=> !rsp_bus.valid)
      else $error("beat after last digit");

endmodule
`default_nettype wire

// ===== src/b2da_ctrl.sv =====
`default_nettype none
module b2da_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire b2da_pkg::status_type status,
   output b2da_pkg::cmd_type         cmd
);

   b2da_pkg::state_type state_ff;
   b2da_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2da_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         b2da_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = b2da_pkg::ST_CONV;
            end
         end
         b2da_pkg::ST_CONV: begin
            cmd.shift = 1'b1;
            if (status.conv_last) begin
               state_in = b2da_pkg::ST_FIND;
            end
         end
         b2da_pkg::ST_FIND: begin
            cmd.find = 1'b1;
            state_in = b2da_pkg::ST_EMIT;
         end
         b2da_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.idx_zero) begin
                  state_in = b2da_pkg::ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = b2da_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== src/b2da_dp.sv =====
`default_nettype none
module b2da_dp (
   input  wire logic                              clock,
   input  wire b2da_pkg::cmd_type                 cmd,
   input  wire logic [b2da_pkg::BinWidth-1:0]     value,
   output b2da_pkg::status_type                   status,
   output logic [b2da_pkg::CharWidth-1:0]         digit_char,
   output logic                                   last_digit
);

   logic [b2da_pkg::BinWidth-1:0] bin_ff, bin_in;
   logic [b2da_pkg::BcdWidth-1:0] bcd_ff, bcd_in;
   logic [b2da_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic [b2da_pkg::IdxWidth-1:0] idx_ff, idx_in;

   logic [b2da_pkg::BcdWidth-1:0] bcd_adj;
   logic [b2da_pkg::IdxWidth-1:0] msd_idx;
   logic [3:0]                    sel_digit;

   always_comb begin
      for (int i = 0; i < b2da_pkg::NumDigits; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= b2da_pkg::AdjustMin)
                             ? bcd_ff[4*i +: 4] + b2da_pkg::AdjustAdd
                             : bcd_ff[4*i +: 4];
      end
   end

   // highest nonzero digit, zero value keeps one digit
   always_comb begin
      msd_idx = '0;
      for (int i = 1; i < b2da_pkg::NumDigits; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            msd_idx = b2da_pkg::IdxWidth'(i);
         end
      end
   end

   always_comb begin
      case (idx_ff)
         3'd0:    sel_digit = bcd_ff[3:0];
         3'd1:    sel_digit = bcd_ff[7:4];
         3'd2:    sel_digit = bcd_ff[11:8];
         3'd3:    sel_digit = bcd_ff[15:12];
         3'd4:    sel_digit = bcd_ff[19:16];
         default: sel_digit = 4'd0;
      endcase
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         bin_in = value;
         bcd_in = '0;
         cnt_in = '0;
      end else if (cmd.shift) begin
         bcd_in = {bcd_adj[b2da_pkg::BcdWidth-2:0], bin_ff[b2da_pkg::BinWidth-1]};
         bin_in = {bin_ff[b2da_pkg::BinWidth-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.find) begin
         idx_in = msd_idx;
      end else if (cmd.step) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
   end

   assign status.conv_last = (cnt_ff == b2da_pkg::LastShift);
   assign status.idx_zero  = (idx_ff == '0);
   assign digit_char       = b2da_pkg::DigitBase + {2'b00, sel_digit};
   assign last_digit       = (idx_ff == '0);

endmodule
`default_nettype wire

// ===== verif/tb_b2da_checker.sv =====
`timescale 1ns / 1ps
module tb_b2da_checker
   import b2da_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [BinWidth-1:0]   req_value,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [CharWidth-1:0]  rsp_digit_char,
   input  wire logic                  rsp_last_digit,
   output int                         error_count,
   output int                         pending_count
);

   localparam int unsigned Radix = 10;

   typedef struct {
      logic [CharWidth-1:0] digit_char;
      logic                 last_digit;
   } digit_beat_type;

   digit_beat_type digit_queue[$];
   int             mismatch_total = 0;

   assign error_count   = mismatch_total;
   assign pending_count = digit_queue.size();

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_total++;
   endtask

   // digits are pushed most significant first, last flag on the ones digit
   task automatic push_decimal_digits(input logic [BinWidth-1:0] number);
      int unsigned    rest;
      int unsigned    lsd_first[NumDigits];
      int             count;
      digit_beat_type beat;
      rest  = number;
      count = 0;
      do begin
         lsd_first[count] = rest % Radix;
         rest = rest / Radix;
         count++;
      end while (rest != 0 && count < NumDigits);
      for (int k = 0; k < count; k++) begin
         beat.digit_char = DigitBase + CharWidth'(lsd_first[count - 1 - k]);
         beat.last_digit = (k == count - 1);
         digit_queue.push_back(beat);
      end
   endtask

   always @(posedge clock) begin
      digit_beat_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (digit_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected digit beat char=%0d last=%0b",
                                         rsp_digit_char, rsp_last_digit));
            end else begin
               want = digit_queue.pop_front();
               if (rsp_digit_char !== want.digit_char)
                  report_mismatch($sformatf("digit_char got %0d want %0d",
                                            rsp_digit_char, want.digit_char));
               if (rsp_last_digit !== want.last_digit)
                  report_mismatch($sformatf("last_digit got %0b want %0b",
                                            rsp_last_digit, want.last_digit));
            end
         end
         if (req_valid && req_ready)
            push_decimal_digits(req_value);
      end
   end

endmodule

// ===== verif/tb_binary_to_decimal_ascii_top.sv =====
`timescale 1ns / 1ps
module tb_binary_to_decimal_ascii_top;
   import b2da_pkg::*;

   localparam int unsigned StallLimit     = 2000;
   localparam int unsigned DrainLimit     = 4000;
   localparam int unsigned DrainCycles    = 40;
   localparam int unsigned RandomPerPhase = 55;
   localparam int unsigned NumDirected    = 20;

   logic        clock;
   logic        reset;
   logic        req_fire;
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned quiet_cycles;
   int unsigned drain_wait;
   int          error_count;
   int          pending_count;

   logic [BinWidth-1:0] directed_values[NumDirected] = '{
      16'd0, 16'd1, 16'd9, 16'd10, 16'd19, 16'd90, 16'd99, 16'd100,
      16'd101, 16'd999, 16'd1000, 16'd9999, 16'd10000, 16'd10001,
      16'd65534, 16'd65535, 16'h8000, 16'h5555, 16'hAAAA, 16'd59999
   };

   b2da_req_if req_bus ();
   b2da_rsp_if rsp_bus ();

   binary_to_decimal_ascii_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tb_b2da_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_value      (req_bus.value),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_digit_char (rsp_bus.digit_char),
      .rsp_last_digit (rsp_bus.last_digit),
      .error_count    (error_count),
      .pending_count  (pending_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      req_fire <= req_bus.valid && req_bus.ready;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [BinWidth-1:0] pick_value();
      case ($urandom_range(3))
         0: return BinWidth'($urandom_range(9));
         1: return BinWidth'($urandom_range(999));
         default: return BinWidth'($urandom);
      endcase
   endfunction

   // entered and left at a falling edge; valid stays high into the next beat
   task automatic send_number(input logic [BinWidth-1:0] number);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         req_bus.value <= BinWidth'($urandom);
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= number;
      do @(negedge clock); while (!req_fire);
   endtask

   initial begin
      reset         = 1'b1;
      req_fire      = 1'b0;
      quiet_cycles  = 0;
      req_idle_pct  = 24;
      rsp_idle_pct  = 83;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_values[i]) send_number(directed_values[i]);
      repeat (RandomPerPhase) send_number(pick_value());

      req_idle_pct = 83;
      rsp_idle_pct = 24;
      repeat (RandomPerPhase) send_number(pick_value());

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (RandomPerPhase) send_number(pick_value());
      req_bus.valid <= 1'b0;

      drain_wait = 0;
      while (pending_count != 0 && drain_wait < DrainLimit) begin
         @(negedge clock);
         drain_wait++;
      end
      if (pending_count != 0) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         repeat (DrainCycles) @(negedge clock);
         if (error_count == 0) begin
            $display("DONE: 0 errors");
         end else begin
            $display("DONE: errors detected");
         end
         $finish;
      end
   end

endmodule

// ===== sim.f =====
src/b2da_pkg.sv
src/b2da_req_if.sv
src/b2da_rsp_if.sv
src/b2da_ctrl.sv
src/b2da_dp.sv
src/binary_to_decimal_ascii_top.sv
verif/tb_b2da_checker.sv
verif/tb_binary_to_decimal_ascii_top.sv
